FILE: design/ats_pkg.sv
// Shared types, widths and codes for the alarm table snooze matcher.
// No dependencies; ats_slot_eval and the top module refer to it by scoped names.
`default_nettype none
package ats_pkg;

  localparam int SLOTS   = 32;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int DELAY_W = 11;
  localparam int DIST_W  = 10;
  localparam int SUM_W   = 13;
  localparam int ENTRY_W = HOUR_W + MIN_W + DELAY_W;

  localparam logic [DELAY_W-1:0] MAX_DELAY     = 11'd1439;
  localparam logic [SUM_W-1:0]   MINS_PER_HOUR = 13'd60;
  localparam logic [SUM_W-1:0]   MINS_PER_DAY  = 13'd1440;
  localparam logic [HOUR_W-1:0]  HOURS_PER_DAY = 5'd24;
  localparam logic [MIN_W-1:0]   MIN_LIMIT     = 6'd60;
  localparam logic [DIST_W-1:0]  THRESH_RESET  = 10'd100;

  localparam logic [1:0] ACT_CREATE = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_CHECK  = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_DUP       = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // One stored alarm slot; the valid mark lives in flip-flops beside the RAM.
  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic [MIN_W-1:0]   minute;
    logic [HOUR_W-1:0]  hour;
  } entry_t;

  // Time carried by the item under work.
  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SUM_W-1:0]  target;
    logic              time_ok;
  } probe_t;

  // Per-slot comparison results.
  typedef struct packed {
    logic               hit;
    logic               ring;
    logic [DELAY_W-1:0] delay_next;
  } eval_t;

endpackage
`default_nettype wire

FILE: design/ats_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
`default_nettype none
module ats_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: design/ats_slot_eval.sv
// Compares one slot read from the table against the item under work and
// computes the snoozed delay. Depends on ats_pkg.
`default_nettype none
module ats_slot_eval (
  input  wire ats_pkg::entry_t entry,
  input  wire logic            slot_valid,
  input  wire ats_pkg::probe_t probe,
  output ats_pkg::eval_t       result
);

  logic [ats_pkg::SUM_W-1:0] total;

  // The shifted time equals the current time exactly when the minute total
  // matches the current minute of day modulo one day; the total never
  // reaches three days, so three compares cover it.
  always_comb begin
    total = ats_pkg::SUM_W'(entry.hour) * ats_pkg::MINS_PER_HOUR
          + ats_pkg::SUM_W'(entry.minute) + ats_pkg::SUM_W'(entry.delay);
    result.hit  = slot_valid && (entry.hour == probe.hour) && (entry.minute == probe.minute);
    result.ring = slot_valid && probe.time_ok &&
                  ((total == probe.target) ||
                   (total == probe.target + ats_pkg::MINS_PER_DAY) ||
                   (total == probe.target + (ats_pkg::MINS_PER_DAY << 1)));
    result.delay_next = (entry.delay < ats_pkg::MAX_DELAY) ?
                        entry.delay + ats_pkg::DELAY_W'(1) : entry.delay;
  end

endmodule
`default_nettype wire

FILE: design/alarm_table_snooze_matcher.sv
// Alarm table with snooze matching: sequencer, valid bits and counters.
// Depends on ats_pkg, ats_ram and ats_slot_eval.
//
// Usage: items enter on the s_ stream (s_tuser holds the action, s_tdata
// the time, the proximity reading and the stop button). Each item yields
// exactly one result item on the m_ stream. cfg_we with cfg_data writes the
// proximity threshold; write it only while the block is idle.
//
// Every item sweeps the whole slot table through the RAM's single read
// port, one slot per cycle, with the read-modify-write of a snoozed delay
// done in the cycle after the read. One step takes the item, the reads are
// issued slot by slot, the RAM then returns the last slot and a final step
// commits the result; no new item is taken until the result is committed.
//
// The result sits in an output register, so the next item is accepted and
// swept while a result waits; if m_tready stays low the block holds at the
// commit step until the register frees up. Reset clears the valid bits and
// the count at once (no clearing pass) and sets the threshold to 100.
`default_nettype none
module alarm_table_snooze_matcher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // time_hour[4:0], time_minute[10:5], distance_reading[20:11],
  // stop_button[21], zero[23:22]
  input  wire logic [23:0] s_tdata,
  // action[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status_code[1:0], ringing_count[7:2], snoozed_count[13:8],
  // keep_polling[14], occupied_count[20:15], zero[23:21]
  output logic      [23:0] m_tdata,
  input  wire logic        cfg_we,
  input  wire logic [9:0]  cfg_data
);

  localparam int IDX_W = ats_pkg::IDX_W;
  localparam int CNT_W = ats_pkg::CNT_W;
  localparam logic [IDX_W:0]   SLOT_END = (IDX_W + 1)'(ats_pkg::SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ats_pkg::SLOTS - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]                  state;
  logic [ats_pkg::DIST_W-1:0]  near_threshold;
  logic [ats_pkg::SLOTS-1:0]   valid_bits;
  logic [CNT_W-1:0]            count;

  logic [1:0]                  item_act;
  logic [ats_pkg::HOUR_W-1:0]  item_hour;
  logic [ats_pkg::MIN_W-1:0]   item_minute;
  logic [ats_pkg::SUM_W-1:0]   item_target;
  logic                        item_time_ok;
  logic                        item_near;
  logic                        item_button;

  logic [IDX_W:0]              scan_idx;
  logic                        pend_valid;
  logic [IDX_W-1:0]            pend_idx;
  logic                        found;
  logic [IDX_W-1:0]            found_idx;
  logic                        free_found;
  logic [IDX_W-1:0]            free_idx;
  logic [CNT_W-1:0]            ring_cnt;
  logic [CNT_W-1:0]            snz_cnt;

  logic [1:0]                  out_status;
  logic [5:0]                  out_ring;
  logic [5:0]                  out_snz;
  logic                        out_poll;
  logic [5:0]                  out_occ;

  logic                        accept;
  logic                        issue;
  logic                        finish_go;
  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  ats_pkg::entry_t             wr_entry;
  logic [ats_pkg::ENTRY_W-1:0] ram_rdata;
  ats_pkg::entry_t             rd_entry;
  ats_pkg::probe_t             probe;
  ats_pkg::eval_t              ev;

  logic [1:0]                  fin_status;
  logic [CNT_W-1:0]            count_next;
  logic                        fin_set;
  logic                        fin_clear;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign issue     = (state == S_SCAN) && (scan_idx < SLOT_END);
  assign finish_go = (state == S_FINISH) && (!m_tvalid || m_tready);
  assign rd_entry  = ats_pkg::entry_t'(ram_rdata);
  assign m_tdata   = {3'b000, out_occ, out_poll, out_snz, out_ring, out_status};

  always_comb begin
    probe.hour    = item_hour;
    probe.minute  = item_minute;
    probe.target  = item_target;
    probe.time_ok = item_time_ok;
  end

  ats_ram #(
    .WIDTH (ats_pkg::ENTRY_W),
    .DEPTH (ats_pkg::SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .re    (issue),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  ats_slot_eval u_eval (
    .entry      (rd_entry),
    .slot_valid (valid_bits[pend_idx]),
    .probe      (probe),
    .result     (ev)
  );

  // Snoozes write back behind the sweep; a create writes at the commit step.
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = pend_idx;
    wr_entry.delay  = ev.delay_next;
    wr_entry.minute = rd_entry.minute;
    wr_entry.hour   = rd_entry.hour;
    if (pend_valid && (item_act == ats_pkg::ACT_CHECK) && ev.ring && item_near) begin
      ram_we = 1'b1;
    end
    if (finish_go && (item_act == ats_pkg::ACT_CREATE) && !found && free_found) begin
      ram_we          = 1'b1;
      ram_waddr       = free_idx;
      wr_entry.delay  = '0;
      wr_entry.minute = item_minute;
      wr_entry.hour   = item_hour;
    end
  end

  always_comb begin
    fin_status = ats_pkg::ST_DONE;
    count_next = count;
    fin_set    = 1'b0;
    fin_clear  = 1'b0;
    unique case (item_act)
      ats_pkg::ACT_CREATE: begin
        if (found) begin
          fin_status = ats_pkg::ST_DUP;
        end else if (free_found) begin
          fin_set    = 1'b1;
          count_next = count + CNT_W'(1);
        end else begin
          fin_status = ats_pkg::ST_FULL;
        end
      end
      ats_pkg::ACT_DELETE: begin
        if (found) begin
          fin_clear  = 1'b1;
          count_next = count - CNT_W'(1);
        end else begin
          fin_status = ats_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      near_threshold <= ats_pkg::THRESH_RESET;
      valid_bits     <= '0;
      count          <= '0;
      m_tvalid       <= 1'b0;
      pend_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        near_threshold <= cfg_data;
      end

      pend_valid <= issue;
      pend_idx   <= scan_idx[IDX_W-1:0];

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            item_act     <= s_tuser;
            item_hour    <= s_tdata[4:0];
            item_minute  <= s_tdata[10:5];
            item_target  <= ats_pkg::SUM_W'(s_tdata[4:0]) * ats_pkg::MINS_PER_HOUR
                          + ats_pkg::SUM_W'(s_tdata[10:5]);
            item_time_ok <= (s_tdata[4:0] < ats_pkg::HOURS_PER_DAY) &&
                            (s_tdata[10:5] < ats_pkg::MIN_LIMIT);
            item_near    <= (s_tdata[20:11] < near_threshold);
            item_button  <= s_tdata[21];
            scan_idx     <= '0;
            found        <= 1'b0;
            free_found   <= 1'b0;
            ring_cnt     <= '0;
            snz_cnt      <= '0;
            state        <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            scan_idx <= scan_idx + (IDX_W + 1)'(1);
          end
          if (pend_valid) begin
            if (ev.hit && !found) begin
              found     <= 1'b1;
              found_idx <= pend_idx;
            end
            if (!valid_bits[pend_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= pend_idx;
            end
            if ((item_act == ats_pkg::ACT_CHECK) && ev.ring) begin
              ring_cnt <= ring_cnt + CNT_W'(1);
              if (item_near) begin
                snz_cnt <= snz_cnt + CNT_W'(1);
              end
            end
            if (pend_idx == LAST_IDX) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (finish_go) begin
            if (fin_set) begin
              valid_bits[free_idx] <= 1'b1;
            end
            if (fin_clear) begin
              valid_bits[found_idx] <= 1'b0;
            end
            count      <= count_next;
            out_status <= fin_status;
            out_ring   <= 6'(ring_cnt);
            out_snz    <= 6'(snz_cnt);
            out_poll   <= (ring_cnt != '0) && (snz_cnt == '0) && !item_button;
            out_occ    <= 6'(count_next);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (finish_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
